// ===== sv/hgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hgcd_pkg
// shared widths, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package hgcd_pkg;

  localparam int unsigned CordicStepsDefault = 32;
  localparam int unsigned TabLen             = 48;
  localparam int unsigned RadiusW            = 23;
  localparam int unsigned DistW              = 25;
  localparam logic [RadiusW-1:0] RadiusReset = 23'd6371000;
  localparam logic signed [47:0] GainQ40     = 48'sd667681663043;
  localparam logic [31:0] PiQ30              = 32'd3373259426;

  // x and y carry q40 values with headroom
  localparam int unsigned XyW = 48;

  typedef logic signed [XyW-1:0] xy_t;
  typedef logic signed [33:0]    ang_t;

  function automatic logic [31:0] atan_turns(input int unsigned idx);
    logic [31:0] t;
    t = 32'd0;
    case (idx)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;  2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;  4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;  8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;  10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
      21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
      24: t = 32'h00000029;  25: t = 32'h00000014;  26: t = 32'h0000000A;
      27: t = 32'h00000005;  28: t = 32'h00000003;  29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/hgcd_rot_stage.sv =====
// ----------------------------------------------------------------------------
// hgcd_rot_stage
// one registered cordic micro-rotation, rotation or vectoring mode
// ----------------------------------------------------------------------------
module hgcd_rot_stage import hgcd_pkg::*; #(
  parameter int unsigned Idx    = 0,
  parameter bit          Vector = 1'b0
) (
  input  logic clk_i,
  input  logic en_i,
  input  xy_t  x_i,
  input  xy_t  y_i,
  input  ang_t z_i,
  output xy_t  x_o,
  output xy_t  y_o,
  output ang_t z_o
);

  xy_t  x_d, y_d, xs, ys;
  ang_t z_d, at;
  logic pos;

  always_comb begin
    xs  = x_i >>> Idx;
    ys  = y_i >>> Idx;
    at  = ang_t'({2'b00, atan_turns(Idx)});
    pos = Vector ? (y_i > 0) : (z_i >= 0);
    if (pos != Vector) begin
      x_d = x_i - ys; y_d = y_i + xs; z_d = z_i - at;
    end else begin
      x_d = x_i + ys; y_d = y_i - xs; z_d = z_i + at;
    end
    if (Vector && !pos) begin
      x_d = x_i - ys; y_d = y_i + xs; z_d = z_i - at;
    end else if (Vector) begin
      x_d = x_i + ys; y_d = y_i - xs; z_d = z_i + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

// ===== sv/hgcd_sincos.sv =====
// ----------------------------------------------------------------------------
// hgcd_sincos
// pipelined rotation cordic, sine and cosine of a binary angle in q30
// ----------------------------------------------------------------------------
module hgcd_sincos import hgcd_pkg::*; #(
  parameter int unsigned CordicSteps = CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        ang_i,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);

  localparam int unsigned N = (CordicSteps > TabLen) ? TabLen : CordicSteps;

  xy_t  xs [N+1];
  xy_t  ys [N+1];
  ang_t zs [N+1];
  logic [1:0] qd [N+1];
  logic [1:0] quad;
  logic [31:0] rr;
  xy_t xr, yr;

  always_comb begin
    quad  = 2'((ang_i + 32'h20000000) >> 30);
    rr    = ang_i - {quad, 30'd0};
    xs[0] = GainQ40;
    ys[0] = '0;
    zs[0] = ang_t'($signed(rr));
    qd[0] = quad;
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    hgcd_rot_stage #(.Idx(i), .Vector(1'b0)) u_st (
      .clk_i, .en_i,
      .x_i(xs[i]), .y_i(ys[i]), .z_i(zs[i]),
      .x_o(xs[i+1]), .y_o(ys[i+1]), .z_o(zs[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) qd[i+1] <= qd[i];
    end
  end

  always_comb begin
    xr = (xs[N] + xy_t'(512)) >>> 10;
    yr = (ys[N] + xy_t'(512)) >>> 10;
    unique case (qd[N])
      2'd0: begin cos_o = 34'(xr);  sin_o = 34'(yr);  end
      2'd1: begin cos_o = 34'(-yr); sin_o = 34'(xr);  end
      2'd2: begin cos_o = 34'(-xr); sin_o = 34'(-yr); end
      default: begin cos_o = 34'(yr); sin_o = 34'(-xr); end
    endcase
  end

endmodule

// ===== sv/hgcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// hgcd_isqrt
// pipelined floor square root of a 61-bit value, two result bits per stage
// ----------------------------------------------------------------------------
module hgcd_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [60:0] v_i,
  output logic [30:0] r_o
);

  // restoring digit recurrence, 31 result bits, one bit per step, two per stage
  localparam int unsigned Bits = 31;
  localparam int unsigned Stg  = (Bits + 1) / 2;

  logic [61:0] rem [Stg+1];
  logic [30:0] root [Stg+1];
  logic [61:0] val [Stg+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign val[0]  = {1'b0, v_i};

  for (genvar s = 0; s < Stg; s++) begin : g_st
    logic [61:0] rm_d, vl_d;
    logic [30:0] rt_d;
    logic [63:0] trial;
    always_comb begin
      rm_d = rem[s]; rt_d = root[s]; vl_d = val[s];
      trial = '0;
      for (int k = 0; k < 2; k++) begin
        if (2 * s + k < Bits) begin
          rm_d  = {rm_d[59:0], vl_d[61:60]};
          vl_d  = {vl_d[59:0], 2'b00};
          trial = {31'd0, rt_d, 2'b01};
          if ({2'b00, rm_d} >= trial) begin
            rm_d = 62'({2'b00, rm_d} - trial);
            rt_d = {rt_d[29:0], 1'b1};
          end else begin
            rt_d = {rt_d[29:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[s+1]  <= rm_d;
        root[s+1] <= rt_d;
        val[s+1]  <= vl_d;
      end
    end
  end

  assign r_o = root[Stg];

endmodule

// ===== sv/haversine_great_circle_distance_core.sv =====
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core
// pipelined great-circle distance by the haversine formula
// ----------------------------------------------------------------------------
//  channel | signals                          | dir
//  in      | in_valid_i / in_ready_o, 4 coords | word in
//  out     | out_valid_o / out_ready_i, dist   | word out
//  cfg     | cfg_we_i / cfg_wdata_i            | radius write
//
//  one word per cycle while the output is not stalled; the pipe holds four angle
//  conversion stages, the two cordic pipes, N = min(CORDIC_STEPS, 48), the
//  16-stage root pipe and five product and clamp stages
//  the whole pipe advances when the output register is empty or taken
//  reset clears valid bits and loads the radius with 6371000
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_core import hgcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [23:0]  first_lat_i,
  input  logic signed [24:0]  first_lon_i,
  input  logic signed [23:0]  second_lat_i,
  input  logic signed [24:0]  second_lon_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DistW-1:0]    distance_m_o,
  input  logic                cfg_we_i,
  input  logic [RadiusW-1:0]  cfg_wdata_i
);

  localparam int unsigned N  = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int unsigned SqStg = 16;
  // stages: 4 conv, N sincos, 1 mul a/b, 1 h, 1 clamp, SqStg sqrt, N vec,
  // 1 theta*pi, 1 r*c
  localparam int unsigned Lat = 4 + N + 1 + 1 + 1 + SqStg + N + 1 + 1;

  // reciprocals of 45, exact floor for the operand ranges used below
  localparam logic [27:0] Recip45Hi = 28'd190887436;
  localparam logic [19:0] Recip45Lo = 20'd745655;

  logic [RadiusW-1:0] radius_q;
  logic adv;
  logic [Lat-2:0] vld_q;
  logic out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Lat-3:0], in_valid_i};
      out_valid_q <= vld_q[Lat-2];
    end
  end

  // angle conversion, round(|v| * 2^sh / 360) = floor((|v| * 2^(sh-3) + 22) / 45)
  // lanes: half dlat, half dlon, lat1, lat2
  logic signed [26:0] cv_w [4];
  logic        sgn1_q [4];
  logic        sgn2_q [4];
  logic        sgn3_q [4];
  logic [26:0] mag1_q [4];
  logic [26:0] mag2_q [4];
  logic [21:0] a2_q [4];
  logic [21:0] a3_q [4];
  logic [5:0]  b_w [4];
  logic [18:0] x_w [4];
  logic [38:0] rp_w [4];
  logic [12:0] r3_q [4];
  logic [34:0] t_w [4];
  logic [31:0] ang_q [4];

  always_comb begin
    cv_w[0] = 27'(second_lat_i) - 27'(first_lat_i);
    cv_w[1] = 27'(second_lon_i) - 27'(first_lon_i);
    cv_w[2] = 27'(first_lat_i);
    cv_w[3] = 27'(second_lat_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        sgn1_q[l] <= cv_w[l][26];
        mag1_q[l] <= cv_w[l][26] ? 27'(-cv_w[l]) : 27'(cv_w[l]);
      end
    end
  end

  // mag = 45 * a + b
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        a2_q[l]   <= 22'((56'(mag1_q[l]) * 56'(Recip45Hi)) >> 33);
        mag2_q[l] <= mag1_q[l];
        sgn2_q[l] <= sgn1_q[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      b_w[l]  = 6'(28'(mag2_q[l]) - 28'(a2_q[l]) * 28'd45);
      x_w[l]  = (19'(b_w[l]) << ((l < 2) ? 12 : 13)) + 19'd22;
      rp_w[l] = 39'(x_w[l]) * 39'(Recip45Lo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        r3_q[l]   <= 13'(rp_w[l] >> 25);
        a3_q[l]   <= a2_q[l];
        sgn3_q[l] <= sgn2_q[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      t_w[l] = (35'(a3_q[l]) << ((l < 2) ? 12 : 13)) + 35'(r3_q[l]);
    end
  end

  // sign restored, wrapped to a turn
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        ang_q[l] <= sgn3_q[l] ? 32'd0 - t_w[l][31:0] : t_w[l][31:0];
      end
    end
  end

  logic signed [33:0] s1, s2, c1, c2, sx0, sx1, sx2, sx3;
  hgcd_sincos #(.CordicSteps(N)) u_sc0 (.clk_i, .en_i(adv), .ang_i(ang_q[0]),
    .sin_o(s1), .cos_o(sx0));
  hgcd_sincos #(.CordicSteps(N)) u_sc1 (.clk_i, .en_i(adv), .ang_i(ang_q[1]),
    .sin_o(s2), .cos_o(sx1));
  hgcd_sincos #(.CordicSteps(N)) u_sc2 (.clk_i, .en_i(adv), .ang_i(ang_q[2]),
    .sin_o(sx2), .cos_o(c1));
  hgcd_sincos #(.CordicSteps(N)) u_sc3 (.clk_i, .en_i(adv), .ang_i(ang_q[3]),
    .sin_o(sx3), .cos_o(c2));

  // products; each stays within about 2^60
  logic signed [67:0] ca_q, cb_q, ss_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ca_q <= 68'(c1) * 68'(s2);
      cb_q <= 68'(c2) * 68'(s2);
      ss_q <= 68'(s1) * 68'(s1);
    end
  end

  logic signed [35:0] a_w, b_w2;
  logic signed [71:0] h_q;
  assign a_w  = 36'((ca_q + 68'sd536870912) >>> 30);
  assign b_w2 = 36'((cb_q + 68'sd536870912) >>> 30);
  always_ff @(posedge clk_i) begin
    if (adv) h_q <= 72'(ss_q) + 72'(a_w) * 72'(b_w2);
  end

  localparam logic signed [71:0] OneQ60 = 72'sd1 <<< 60;
  logic [60:0] hc_q, hn_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (h_q < 0) begin
        hc_q <= '0; hn_q <= 61'(OneQ60);
      end else if (h_q > OneQ60) begin
        hc_q <= 61'(OneQ60); hn_q <= '0;
      end else begin
        hc_q <= 61'(h_q); hn_q <= 61'(OneQ60 - h_q);
      end
    end
  end

  logic [30:0] r1, r2;
  hgcd_isqrt u_sq1 (.clk_i, .en_i(adv), .v_i(hc_q), .r_o(r1));
  hgcd_isqrt u_sq2 (.clk_i, .en_i(adv), .v_i(hn_q), .r_o(r2));

  xy_t  vx [N+1];
  xy_t  vy [N+1];
  ang_t vz [N+1];
  assign vx[0] = xy_t'({r2, 10'd0});
  assign vy[0] = xy_t'({r1, 10'd0});
  assign vz[0] = '0;
  for (genvar i = 0; i < N; i++) begin : g_vec
    hgcd_rot_stage #(.Idx(i), .Vector(1'b1)) u_st (
      .clk_i, .en_i(adv),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end

  logic [30:0] th;
  always_comb begin
    if (vz[N] < 0) th = '0;
    else if (vz[N] > ang_t'(34'sd1 <<< 30)) th = 31'd1 << 30;
    else th = 31'(vz[N]);
  end

  logic [38:0] c36_q;
  always_ff @(posedge clk_i) begin
    if (adv) c36_q <= 39'(({32'd0, th} * {31'd0, PiQ30} + 63'd8388608) >> 24);
  end

  logic [DistW-1:0] dist_q;
  always_ff @(posedge clk_i) begin
    if (adv) dist_q <= DistW'(({39'd0, radius_q} * {23'd0, c36_q} + 62'd34359738368) >> 36);
  end
  assign distance_m_o = dist_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_m_o))
    else $error("output word changed while stalled");
  a_stall_frz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipe moved during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready with empty output");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// streams point pairs through the distance core under random bursts and
// output stalls, and checks every distance against a bit-exact fixed-point
// model of the haversine and cordic datapath, over several radius settings
// ----------------------------------------------------------------------------
module testbench import hgcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Steps      = CordicStepsDefault;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned RandPerSet = 70;
  localparam longint      OneQ60     = 64'sd1 << 60;

  localparam logic [31:0] ArcTab [TabLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

  typedef struct {
    logic signed [23:0] lat1;
    logic signed [24:0] lon1;
    logic signed [23:0] lat2;
    logic signed [24:0] lon2;
  } pair_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] first_lat_i = '0;
  logic signed [24:0] first_lon_i = '0;
  logic signed [23:0] second_lat_i = '0;
  logic signed [24:0] second_lon_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [DistW-1:0]   distance_m_o;
  logic               cfg_we_i = 1'b0;
  logic [RadiusW-1:0] cfg_wdata_i = '0;

  logic [RadiusW-1:0] radius_m;
  logic [DistW-1:0]   dist_queue[$];
  int unsigned        mismatches = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        burst_left = 0;
  logic               ready_slow = 1'b0;

  haversine_great_circle_distance_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_lat_i, .first_lon_i, .second_lat_i, .second_lon_i,
    .out_valid_o, .out_ready_i, .distance_m_o, .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --- predictor ------------------------------------------------------------

  // round(|v| * 2^sh / 360) with ties away from zero, wrapped to a turn
  function automatic logic [31:0] binary_angle(input longint v, input int sh);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q   = ((mag << sh) + 180) / 360;
    return (v < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic void sine_cosine(input logic [31:0] p,
                                      output longint s, output longint c);
    logic [1:0]  quad;
    logic [31:0] rr;
    longint x, y, z, nx, ny;
    quad = 2'((p + 32'h20000000) >> 30);
    rr   = p - {quad, 30'd0};
    z    = longint'($signed(rr));
    x    = longint'(GainQ40);
    y    = 0;
    for (int i = 0; i < Steps && i < TabLen; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ArcTab[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ArcTab[i]);
      end
      x = nx;
      y = ny;
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint central_turns(input longint x, input longint y);
    longint z, nx, ny;
    z = 0;
    for (int i = 0; i < Steps && i < TabLen; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ArcTab[i]);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ArcTab[i]);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic [DistW-1:0] great_circle(input pair_t p,
                                                    input logic [RadiusW-1:0] rad);
    longint s1, s2, c1, c2, unused, a, b, h, theta;
    longint unsigned r1, r2, c36, d;
    sine_cosine(binary_angle(longint'(p.lat2) - longint'(p.lat1), 15), s1, unused);
    sine_cosine(binary_angle(longint'(p.lon2) - longint'(p.lon1), 15), s2, unused);
    sine_cosine(binary_angle(longint'(p.lat1), 16), unused, c1);
    sine_cosine(binary_angle(longint'(p.lat2), 16), unused, c2);
    a = (c1 * s2 + (64'sd1 << 29)) >>> 30;
    b = (c2 * s2 + (64'sd1 << 29)) >>> 30;
    h = s1 * s1 + a * b;
    if (h < 0) h = 0;
    if (h > OneQ60) h = OneQ60;
    r1 = floor_root(h);
    r2 = floor_root(OneQ60 - h);
    theta = central_turns(longint'(r2 << 10), longint'(r1 << 10));
    if (theta < 0) theta = 0;
    if (theta > (64'sd1 << 30)) theta = 64'sd1 << 30;
    c36 = (longint'(theta) * longint'(PiQ30) + (64'd1 << 23)) >> 24;
    d   = (longint'(rad) * c36 + (64'd1 << 35)) >> 36;
    return d[DistW-1:0];
  endfunction

  // --- stimulus -------------------------------------------------------------

  task automatic send_pair(input pair_t p, input int forced);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    first_lat_i  <= p.lat1;
    first_lon_i  <= p.lon1;
    second_lat_i <= p.lat2;
    second_lon_i <= p.lon2;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    dist_queue.push_back(forced >= 0 ? DistW'(forced) : great_circle(p, radius_m));
  endtask

  // sender stops until the pipe is empty, then the radius may change
  task automatic drain_and_set(input logic [RadiusW-1:0] rad);
    in_valid_i <= 1'b0;
    wait (dist_queue.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rad;
    radius_m     = rad;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    if ($urandom_range(0, 4) == 0) begin
      // full field width, out-of-range angles wrap
      p.lat1 = 24'($urandom);
      p.lon1 = 25'($urandom);
      p.lat2 = 24'($urandom);
      p.lon2 = 25'($urandom);
    end else begin
      p.lat1 = 24'($signed($urandom_range(0, 11796480)) - 5898240);
      p.lon1 = 25'($signed($urandom_range(0, 23592960)) - 11796480);
      if ($urandom_range(0, 3) == 0) begin
        // nearby points
        p.lat2 = 24'(p.lat1 + $signed($urandom_range(0, 2000)) - 1000);
        p.lon2 = 25'(p.lon1 + $signed($urandom_range(0, 2000)) - 1000);
      end else begin
        p.lat2 = 24'($signed($urandom_range(0, 11796480)) - 5898240);
        p.lon2 = 25'($signed($urandom_range(0, 23592960)) - 11796480);
      end
    end
    return p;
  endfunction

  pair_t corner_rows [16] = '{
    '{24'sd0, 25'sd0, 24'sd0, 25'sd0},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd11796480},
    '{24'sd5898240, 25'sd0, -24'sd5898240, 25'sd0},
    '{24'sd5898240, 25'sd0, 24'sd5898240, 25'sd11796480},
    '{24'sd0, -25'sd11796480, 24'sd0, 25'sd11796480},
    '{-24'sd5898240, -25'sd11796480, 24'sd5898240, 25'sd11796480},
    '{24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000},
    '{24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd1},
    '{24'sd0, 25'sd0, 24'sd1, 25'sd0},
    '{24'sd2949120, 25'sd655360, -24'sd1966080, -25'sd7864320},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd5898240},
    '{24'sd6553600, 25'sd0, 24'sd0, 25'sd0},
    '{24'sd0, 25'sd0, 24'sd0, -25'sd11796480},
    '{-24'sd1, -25'sd1, -24'sd1, -25'sd1},
    '{24'sd0, 25'sd0, 24'sd0, 25'sd32768}
  };

  logic [RadiusW-1:0] radius_steps [4] = '{23'd1, 23'd8000000, 23'h7FFFFF, 23'd0};

  initial begin
    radius_m = RadiusReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset radius, corner points and random pairs
    foreach (corner_rows[i]) send_pair(corner_rows[i], -1);
    for (int n = 0; n < RandPerSet; n++) send_pair(random_pair(), -1);

    // zero radius gives zero distance everywhere
    drain_and_set(23'd0);
    foreach (corner_rows[i]) send_pair(corner_rows[i], 0);

    foreach (radius_steps[k]) begin
      drain_and_set(radius_steps[k] == 0 ? 23'($urandom_range(1, 8388607))
                                         : radius_steps[k]);
      foreach (corner_rows[i]) if (i % 4 == k) send_pair(corner_rows[i], -1);
      for (int n = 0; n < RandPerSet; n++) send_pair(random_pair(), -1);
    end

    in_valid_i <= 1'b0;
    wait (dist_queue.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // --- receiver, checker, watchdog -----------------------------------------

  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) ready_slow <= ~ready_slow;
    out_ready_i <= ready_slow ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: distance %0d", distance_m_o);
      end else if (distance_m_o !== dist_queue[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance mismatch: expected %0d, got %0d", dist_queue[0], distance_m_o);
        void'(dist_queue.pop_front());
      end else begin
        void'(dist_queue.pop_front());
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

endmodule
